[rtl/sitda_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies; sitda_dabble, sitda_emit and the top level import this package.
package sitda_pkg;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } sitda_state_t;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // Double-dabble correction: a BCD digit at or above the limit gets the offset.
  localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [3:0] BCD_ADJ       = 4'd3;
  localparam logic [3:0] BCD_ZERO      = 4'd0;

endpackage

[rtl/sitda_in_if.sv]
// Input channel: one signed integer word with valid/ready handshake.
// Depends on nothing.
interface sitda_in_if #(
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

[rtl/sitda_out_if.sv]
// Output channel: one ASCII character word plus end-of-number flag.
// Depends on nothing.
interface sitda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

[rtl/sitda_dabble.sv]
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on sitda_pkg.
module sitda_dabble
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] mag,
  output logic                  done,
  output logic [NDIG*4-1:0]     bcd
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] bin;
  logic [NDIG*4-1:0]     bcd_adj;
  logic [CW-1:0]         cnt;

  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[d*4 +: 4] >= BCD_ADJ_LIMIT) begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4] + BCD_ADJ;
      end else begin
        bcd_adj[d*4 +: 4] = bcd[d*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CW'(VALUE_BITS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CW'(1);
      done <= (cnt == CW'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Shift the next magnitude bit into the corrected BCD digits.
  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (cnt != '0) begin
      bin <= {bin[VALUE_BITS-2:0], 1'b0};
      bcd <= {bcd_adj[NDIG*4-2:0], bin[VALUE_BITS-1]};
    end
  end

endmodule

[rtl/sitda_emit.sv]
// Digit emitter: shifts BCD digits out one per cycle while the output register can load, drops leading zeros,
// prepends the sign and holds each character word in an output register.
// Depends on sitda_pkg and sitda_out_if.
module sitda_emit
  import sitda_pkg::*;
#(
  parameter int NDIG = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               negative,
  input  logic [NDIG*4-1:0]  bcd,
  output logic               busy,
  sitda_out_if.source        dout
);

  localparam int LW = $clog2(NDIG + 1);

  logic [NDIG*4-1:0] dig;
  logic [LW-1:0]     left;
  logic              active;
  logic              started;
  logic              sign_pend;
  logic              ovalid;
  logic [7:0]        ochar;
  logic              olast;
  logic              can_load;
  logic [3:0]        top;
  logic              is_last;
  logic              emit_word;

  assign can_load = !ovalid || dout.ready;
  assign top      = dig[NDIG*4-1 -: 4];
  assign is_last  = (left == LW'(1));
  assign busy     = active;

  // Load a word for the sign, or for a digit that is not a dropped leading zero.
  assign emit_word = active && can_load &&
                     (sign_pend || top != BCD_ZERO || started || is_last);

  assign dout.valid     = ovalid;
  assign dout.character = ochar;
  assign dout.last      = olast;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      started   <= 1'b0;
      sign_pend <= 1'b0;
      ovalid    <= 1'b0;
      left      <= '0;
    end else begin
      if (emit_word) begin
        ovalid <= 1'b1;
      end else if (dout.ready) begin
        ovalid <= 1'b0;
      end
      if (start) begin
        active    <= 1'b1;
        started   <= 1'b0;
        sign_pend <= negative;
        left      <= LW'(NDIG);
      end else if (active && can_load) begin
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else begin
          left <= left - LW'(1);
          // Drop a leading zero unless it is the only digit left.
          if (top != BCD_ZERO || started || is_last) begin
            started <= 1'b1;
            if (is_last) begin
              active <= 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dig <= bcd;
    end else if (active && can_load) begin
      if (sign_pend) begin
        ochar <= CHAR_MINUS;
        olast <= 1'b0;
      end else begin
        dig   <= {dig[NDIG*4-5:0], BCD_ZERO};
        ochar <= CHAR_ZERO + {4'd0, top};
        olast <= is_last;
      end
    end
  end

endmodule

[rtl/signed_int_to_decimal_ascii.sv]
// Top level: signed integer to decimal ASCII text, one character per word.
// Depends on sitda_pkg, sitda_in_if, sitda_out_if, sitda_dabble, sitda_emit.
//
//   channel  dir  payload                     handshake
//   din      in   value[VALUE_BITS-1:0] signed valid/ready
//   dout     out  character[7:0], last         valid/ready
//
// One number passes an accept step, the bit-serial BCD converter (one step
// per magnitude bit), a hand-off of the digits to the emitter, one digit
// step per character or dropped leading zero, one more for a sign, and a
// return to idle.
// din is ready only while the sequencer idles; the last character may still
// wait in the output register while the next number is converted.
// Synchronous active-high reset clears the sequencer and the output valid.
// A stalled dout holds the current character and pauses digit shifting.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  sitda_in_if.sink    din,
  sitda_out_if.source dout
);

  localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;

  sitda_state_t state, state_next;

  logic                  accept;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  conv_done;
  logic [NDIG*4-1:0]     bcd;
  logic                  emit_busy;

  assign accept = din.valid && din.ready;

  // Magnitude fits unsigned VALUE_BITS, including the most negative value.
  assign mag = din.value[VALUE_BITS-1] ? (~din.value + VALUE_BITS'(1))
                                       : din.value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= din.value[VALUE_BITS-1];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept)     state_next = ST_CONV;
      ST_CONV: if (conv_done)  state_next = ST_EMIT;
      ST_EMIT: if (!emit_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    din.ready = 1'b0;
    unique case (state)
      ST_IDLE: din.ready = 1'b1;
      ST_CONV: din.ready = 1'b0;
      ST_EMIT: din.ready = 1'b0;
      default: din.ready = 1'b0;
    endcase
  end

  sitda_dabble #(
    .VALUE_BITS(VALUE_BITS),
    .NDIG      (NDIG)
  ) u_dabble (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .mag  (mag),
    .done (conv_done),
    .bcd  (bcd)
  );

  sitda_emit #(
    .NDIG(NDIG)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .start   (conv_done),
    .negative(neg),
    .bcd     (bcd),
    .busy    (emit_busy),
    .dout    (dout)
  );

endmodule
